### hdl/assert_macros.svh
// Assertion macros used by the responder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/tspr_pkg.sv
package tspr_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RX    = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Frame select codes.
  localparam logic [1:0] SEL_GPS   = 2'd0;
  localparam logic [1:0] SEL_POWER = 2'd1;
  localparam logic [1:0] SEL_VARIO = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_AWAIT = 3'd1,
    PH_GPS   = 3'd2,
    PH_POWER = 3'd3,
    PH_VARIO = 3'd4
  } phase_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_REQUEST   = 3'd0;
  localparam logic [2:0] REG_GPS_CODE  = 3'd1;
  localparam logic [2:0] REG_PWR_CODE  = 3'd2;
  localparam logic [2:0] REG_VARIO_CODE = 3'd3;
  localparam logic [2:0] REG_GPS_LEN   = 3'd4;
  localparam logic [2:0] REG_PWR_LEN   = 3'd5;
  localparam logic [2:0] REG_VARIO_LEN = 3'd6;
  localparam logic [2:0] REG_DELAY     = 3'd7;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int LEN_W   = 7;
  localparam int ELAPSED_W = 5;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 5'd31;

  typedef struct packed {
    logic [7:0] request_code;
    logic [7:0] gps_sensor_code;
    logic [7:0] power_sensor_code;
    logic [7:0] vario_sensor_code;
    logic [6:0] gps_frame_length;
    logic [6:0] power_frame_length;
    logic [6:0] vario_frame_length;
    logic [3:0] answer_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [1:0] frame_select;
    logic [5:0] byte_index;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [2:0] phase;
  } result_t;

  // Control word handed from the sequencer to the checksum stage.
  typedef struct packed {
    logic       tx_valid;
    logic       tx_last;
    logic       clr_sum;
    logic [2:0] phase;
  } step_t;

endpackage

### hdl/tspr_ram.sv
module tspr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/tspr_cfg.sv
module tspr_cfg
  import tspr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cfg_t               cfg
);

  logic       wr;
  logic [2:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.request_code       <= 8'd128;
      cfg.gps_sensor_code    <= 8'd138;
      cfg.power_sensor_code  <= 8'd142;
      cfg.vario_sensor_code  <= 8'd137;
      cfg.gps_frame_length   <= 7'd45;
      cfg.power_frame_length <= 7'd45;
      cfg.vario_frame_length <= 7'd45;
      cfg.answer_delay_ms    <= 4'd5;
    end else if (wr) begin
      unique case (idx)
        REG_REQUEST:    cfg.request_code       <= pwdata[7:0];
        REG_GPS_CODE:   cfg.gps_sensor_code    <= pwdata[7:0];
        REG_PWR_CODE:   cfg.power_sensor_code  <= pwdata[7:0];
        REG_VARIO_CODE: cfg.vario_sensor_code  <= pwdata[7:0];
        REG_GPS_LEN:    cfg.gps_frame_length   <= pwdata[6:0];
        REG_PWR_LEN:    cfg.power_frame_length <= pwdata[6:0];
        REG_VARIO_LEN:  cfg.vario_frame_length <= pwdata[6:0];
        REG_DELAY:      cfg.answer_delay_ms    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_REQUEST:    prdata = {24'd0, cfg.request_code};
      REG_GPS_CODE:   prdata = {24'd0, cfg.gps_sensor_code};
      REG_PWR_CODE:   prdata = {24'd0, cfg.power_sensor_code};
      REG_VARIO_CODE: prdata = {24'd0, cfg.vario_sensor_code};
      REG_GPS_LEN:    prdata = {25'd0, cfg.gps_frame_length};
      REG_PWR_LEN:    prdata = {25'd0, cfg.power_frame_length};
      REG_VARIO_LEN:  prdata = {25'd0, cfg.vario_frame_length};
      REG_DELAY:      prdata = {28'd0, cfg.answer_delay_ms};
      default:        prdata = '0;
    endcase
  end

endmodule

### hdl/tspr_ctrl.sv
module tspr_ctrl
  import tspr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 64,
  parameter int BYTE_GAP_MS = 1,
  localparam int AW = $clog2(3 * MAX_FRAME_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  item_t         item,
  input  cfg_t          cfg,
  output step_t         step,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata
);

  localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME_BYTES);
  localparam logic [3:0] GAP     = 4'(BYTE_GAP_MS);

  phase_t               phase, phase_next;
  logic [LEN_W-1:0]     pos, pos_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;
  logic                 in_delay, in_delay_next;

  logic                 sending, tick, rx, fire, has_byte, is_last, clr_sum;
  logic [LEN_W-1:0]     len_raw;
  logic [8:0]           len_eff, pos_ext;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [3:0]           limit;
  logic [1:0]           frame;

  assign tick = accept && (item.operation == OP_TICK);
  assign rx   = accept && (item.operation == OP_RX);
  assign sending = (phase == PH_GPS) || (phase == PH_POWER) || (phase == PH_VARIO);

  always_comb begin
    unique case (phase)
      PH_GPS:   begin len_raw = cfg.gps_frame_length;   frame = SEL_GPS;   end
      PH_POWER: begin len_raw = cfg.power_frame_length; frame = SEL_POWER; end
      PH_VARIO: begin len_raw = cfg.vario_frame_length; frame = SEL_VARIO; end
      default:  begin len_raw = '0;                     frame = SEL_GPS;   end
    endcase
  end

  assign len_eff     = ({2'b00, len_raw} > MAX_LEN) ? MAX_LEN : {2'b00, len_raw};
  assign pos_ext     = {2'b00, pos};
  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
  assign limit       = in_delay ? cfg.answer_delay_ms : GAP;
  assign fire        = tick && sending && (elapsed_inc > {1'b0, limit});
  assign has_byte    = pos_ext < len_eff;
  assign is_last     = pos_ext == (len_eff - 9'd1);
  assign clr_sum     = rx && (phase == PH_AWAIT);

  // Next state.
  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    elapsed_next  = elapsed;
    in_delay_next = in_delay;
    if (tick && sending) begin
      elapsed_next = elapsed_inc;
      if (fire) begin
        elapsed_next  = '0;
        in_delay_next = 1'b0;
        if (has_byte) begin
          pos_next = pos + 1'b1;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    end else if (rx) begin
      unique case (phase)
        PH_IDLE: begin
          if (item.rx_byte == cfg.request_code) begin
            phase_next = PH_AWAIT;
          end
        end
        PH_AWAIT: begin
          pos_next      = '0;
          elapsed_next  = '0;
          in_delay_next = 1'b1;
          if (item.rx_byte == cfg.gps_sensor_code) begin
            phase_next = PH_GPS;
          end else if (item.rx_byte == cfg.power_sensor_code) begin
            phase_next = PH_POWER;
          end else if (item.rx_byte == cfg.vario_sensor_code) begin
            phase_next = PH_VARIO;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          if (in_delay) begin
            phase_next = PH_IDLE;
          end
        end
      endcase
    end
  end

  // Outputs: the step word and the frame store accesses.
  always_comb begin
    step.tx_valid = fire && has_byte;
    step.tx_last  = fire && has_byte && is_last;
    step.clr_sum  = clr_sum;
    step.phase    = phase_next;
    ram_re        = accept;
    ram_raddr     = AW'(32'(frame) * MAX_FRAME_BYTES + 32'(pos));
    ram_we        = accept && (item.operation == OP_WRITE) &&
                    (item.frame_select <= SEL_VARIO) &&
                    (32'(item.byte_index) < MAX_FRAME_BYTES);
    ram_waddr     = AW'(32'(item.frame_select) * MAX_FRAME_BYTES + 32'(item.byte_index));
    ram_wdata     = item.byte_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      pos      <= '0;
      elapsed  <= '0;
      in_delay <= 1'b0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      elapsed  <= elapsed_next;
      in_delay <= in_delay_next;
    end
  end

endmodule

### hdl/telemetry_sensor_poll_responder_core.sv
// Channel   | Direction | Handshake                   | Beat
// item      | in        | item_valid / item_stall     | item_t (operation, rx_byte, ...)
// result    | out       | result_valid / result_stall | result_t (tx_valid, tx_byte, ...)
// config    | in        | psel / penable / pwrite     | 32-bit register at 4 * index
//
// One item beat is taken per cycle while item_stall is low; each gives exactly one result beat.
// The depth is set by the frame store read and the result register.
// Reset (rst, synchronous) clears the sequencer, the checksum and the pipeline valids;
// the frame store itself is not cleared and holds garbage until written.
// A stalled result holds the pipeline; item_stall rises only while both stages are full.
`include "assert_macros.svh"

module telemetry_sensor_poll_responder_core
  import tspr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 64,
  parameter int BYTE_GAP_MS = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = $clog2(3 * MAX_FRAME_BYTES);

  cfg_t          cfg;
  step_t         step;
  step_t         s1;
  logic          s1_valid;
  logic          accept, out_adv, s1_adv;
  logic          ram_re, ram_we;
  logic [AW-1:0] ram_raddr, ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [7:0]    sum, sum_next;
  logic [7:0]    tx_byte;

  assign pready = 1'b1;

  tspr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The result register frees up whenever it is empty or being taken. The
  // checksum stage moves into it at that time, so a new beat can enter
  // each cycle as long as the downstream side keeps up.
  assign out_adv    = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && out_adv;
  assign item_stall = s1_valid && !out_adv;
  assign accept     = item_valid && !item_stall;

  // Stage 0: the sequencer updates phase, position and timers and issues the
  // frame store read for the byte it decides to send.
  tspr_ctrl #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .BYTE_GAP_MS     (BYTE_GAP_MS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg       (cfg),
    .step      (step),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // The frame store holds three frames back to back. The read port is only
  // enabled on an accepted beat, so the read data stays put while stage 1
  // is held by a stall.
  tspr_ram #(
    .WIDTH (8),
    .DEPTH (3 * MAX_FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage 1: the running checksum lives here, next to the read data, so a
  // checksum byte right after a data byte sees the updated sum without
  // any forwarding.
  always_comb begin
    if (!s1.tx_valid) begin
      tx_byte = 8'd0;
    end else if (s1.tx_last) begin
      tx_byte = sum;
    end else begin
      tx_byte = ram_rdata;
    end
    if (s1.clr_sum) begin
      sum_next = 8'd0;
    end else if (s1.tx_valid && !s1.tx_last) begin
      sum_next = sum + ram_rdata;
    end else begin
      sum_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      sum          <= 8'd0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_adv);
      if (out_adv) begin
        result_valid <= s1_valid;
      end
      if (s1_adv) begin
        sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= step;
    end
    if (s1_adv) begin
      result.tx_valid <= s1.tx_valid;
      result.tx_byte  <= tx_byte;
      result.tx_last  <= s1.tx_last;
      result.phase    <= s1.phase;
    end
  end

  `ASSERT_SAME(a_last_is_sent, clk, rst, result_valid, !result.tx_last || result.tx_valid)
  `ASSERT_SAME(a_stall_needs_full, clk, rst, item_stall, s1_valid && result_valid)
  `ASSERT_NEXT(a_accept_fills, clk, rst, accept, s1_valid)

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Polled sensor responder testbench.
//
// Items go in as beats on the item channel and every beat gives exactly one
// result beat. A scoreboard predicts the result of each accepted item from
// its own copy of the responder state, configuration and frame store. It
// compares the result beats, field by field, in order.
//
// The run has four parts:
//  * A preload writes every entry of the three frames, so that no answer
//    ever sends a byte that was never written.
//  * A short directed table covers idle ticks, the unused operation, ignored
//    writes, request and id decoding (including the first match winning when
//    two ids are equal), an abort during the answer delay, a dropped byte
//    while sending, a write into the frame being sent, and the checksum byte.
//  * Random phases, each under its own register setting, drive mostly
//    well-formed polls (request, id, then ticks) with random frame writes
//    and line noise mixed in. Some polls are broken on purpose. The settings
//    include zero, one and over-long frame lengths and the longest delay.
//  * A drain that waits for every expected beat.
//
// Both sides insert random gaps. Once, the result side holds off for a long
// stretch, so that the two pipeline stages fill and the item side stalls.
module testbench;
  import tspr_pkg::*;

  localparam int FRAME_BYTES  = 64;
  localparam int GAP_TICKS    = 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 120;
  localparam int STALL_LIMIT  = 1000;

  typedef struct {
    item_t  beat;
    bit     pinned;
    phase_t ph;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  item_t                item;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // The directed rows carry a typed phase next to the beat. While pin_check
  // is set, the scoreboard expects an idle line with that phase.
  bit                   pin_check;
  phase_t               pin_phase;

  // Pacing controls that the stimulus and the result sink share.
  bit                   calm_sender;
  bit                   calm_sink;
  bit                   hold_off_pending;

  int                   mismatches;
  int                   idle_cycles;
  int                   issued;
  bit                   busy;
  result_t              predicted;
  result_t              want;
  result_t              expected_tx[$];

  // The scoreboard's view of the responder. The registers start at their
  // reset values and follow every write on the configuration port.
  cfg_t shadow_cfg = '{8'd128, 8'd138, 8'd142, 8'd137, 7'd45, 7'd45, 7'd45, 4'd5};
  phase_t               resp_phase = PH_IDLE;
  int                   tx_pos = 0;
  logic [7:0]           line_sum = 8'h00;
  int                   ms_count = 0;
  bit                   holding_delay = 1'b0;
  logic [7:0]           frame_bytes [0:3*FRAME_BYTES-1];

  telemetry_sensor_poll_responder_core #(
    .MAX_FRAME_BYTES(FRAME_BYTES),
    .BYTE_GAP_MS(GAP_TICKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // Returns the frame length after clamping. Lengths above the frame size
  // (FRAME_BYTES) send a full frame's worth of bytes.
  function automatic int frame_length(input logic [1:0] fsel);
    int n;
    case (fsel)
      SEL_GPS:   n = shadow_cfg.gps_frame_length;
      SEL_POWER: n = shadow_cfg.power_frame_length;
      default:   n = shadow_cfg.vario_frame_length;
    endcase
    return (n > FRAME_BYTES) ? FRAME_BYTES : n;
  endfunction

  // Advances the scoreboard's responder by one item and returns the line
  // output that the item should produce.
  function automatic result_t advance_responder(input item_t b);
    result_t    r;
    int         lim;
    int         len;
    logic [1:0] fsel;
    r = '0;
    case (b.operation)
      OP_TICK: begin
        // Ticks matter only while an answer is running. The first byte waits
        // for the answer delay. Every later byte waits for the byte gap.
        if (resp_phase == PH_GPS || resp_phase == PH_POWER || resp_phase == PH_VARIO) begin
          lim = holding_delay ? int'(shadow_cfg.answer_delay_ms) : GAP_TICKS;
          if (ms_count < int'(ELAPSED_MAX)) ms_count++;
          if (ms_count > lim) begin
            fsel = 2'(int'(resp_phase) - int'(PH_GPS));
            len = frame_length(fsel);
            ms_count = 0;
            holding_delay = 1'b0;
            if (tx_pos < len) begin
              if (tx_pos == len - 1) begin
                r.tx_byte = line_sum;
                r.tx_last = 1'b1;
              end else begin
                r.tx_byte = frame_bytes[int'(fsel) * FRAME_BYTES + tx_pos];
                line_sum = line_sum + r.tx_byte;
              end
              r.tx_valid = 1'b1;
              tx_pos++;
            end else begin
              resp_phase = PH_IDLE;
            end
          end
        end
      end
      OP_RX: begin
        if (resp_phase == PH_IDLE) begin
          if (b.rx_byte == shadow_cfg.request_code) resp_phase = PH_AWAIT;
        end else if (resp_phase == PH_AWAIT) begin
          // The ids are checked in a fixed order, so the first match wins.
          tx_pos = 0;
          line_sum = 8'h00;
          ms_count = 0;
          holding_delay = 1'b1;
          if (b.rx_byte == shadow_cfg.gps_sensor_code) resp_phase = PH_GPS;
          else if (b.rx_byte == shadow_cfg.power_sensor_code) resp_phase = PH_POWER;
          else if (b.rx_byte == shadow_cfg.vario_sensor_code) resp_phase = PH_VARIO;
          else resp_phase = PH_IDLE;
        end else if (holding_delay) begin
          // Line traffic during the answer delay aborts the answer. After the
          // delay, the byte is simply dropped.
          resp_phase = PH_IDLE;
        end
      end
      OP_WRITE: begin
        if (b.frame_select <= SEL_VARIO)
          frame_bytes[int'(b.frame_select) * FRAME_BYTES + int'(b.byte_index)] = b.byte_value;
      end
      default: begin
      end
    endcase
    r.phase = resp_phase;
    return r;
  endfunction

  function automatic item_t beat_of(input logic [1:0] op, input logic [7:0] rx,
                                    input logic [1:0] fsel, input logic [5:0] idx,
                                    input logic [7:0] val);
    item_t b;
    b.operation = op;
    b.rx_byte = rx;
    b.frame_select = fsel;
    b.byte_index = idx;
    b.byte_value = val;
    return b;
  endfunction

  function automatic item_t noise_beat();
    return beat_of(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                   8'($urandom_range(0, 255)));
  endfunction

  function automatic row_t row(input item_t b, input bit pinned = 1'b0,
                               input phase_t ph = PH_IDLE);
    row_t t;
    t.beat = b;
    t.pinned = pinned;
    t.ph = ph;
    return t;
  endfunction

  // Most gaps are zero or short, and a few are long. Calm stretches have no
  // gaps at all.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Offers one beat. The task returns at the rising edge where the beat is
  // taken, and valid stays high until the next offer or park_sender.
  task automatic offer(input item_t b, input bit pinned = 1'b0,
                       input phase_t ph = PH_IDLE);
    int unsigned gap;
    gap = pick_gap(calm_sender);
    @(negedge clk);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= b;
    pin_check <= pinned;
    pin_phase <= ph;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    issued++;
  endtask

  task automatic park_sender();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_read(input logic [2:0] idx, output logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Loads a full register setting once nothing is in flight. Each register is
  // read back. With scramble set, the bits above each field carry garbage
  // that the register must drop.
  task automatic load_settings(input cfg_t c, input bit scramble);
    logic [31:0] field;
    logic [31:0] mask;
    logic [31:0] readback;
    logic [2:0]  idx;
    int          i;
    park_sender();
    while (expected_tx.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    for (i = 0; i < 8; i++) begin
      idx = 3'(i);
      case (idx)
        REG_REQUEST:    begin field = c.request_code;       mask = 32'hff; end
        REG_GPS_CODE:   begin field = c.gps_sensor_code;    mask = 32'hff; end
        REG_PWR_CODE:   begin field = c.power_sensor_code;  mask = 32'hff; end
        REG_VARIO_CODE: begin field = c.vario_sensor_code;  mask = 32'hff; end
        REG_GPS_LEN:    begin field = c.gps_frame_length;   mask = 32'h7f; end
        REG_PWR_LEN:    begin field = c.power_frame_length; mask = 32'h7f; end
        REG_VARIO_LEN:  begin field = c.vario_frame_length; mask = 32'h7f; end
        default:        begin field = c.answer_delay_ms;    mask = 32'h0f; end
      endcase
      reg_write(idx, scramble ? (field | ($urandom() & ~mask)) : field);
      reg_read(idx, readback);
      if (readback !== field) begin
        $error("register %0d mismatch: expected 0x%0h, actual 0x%0h", i, field, readback);
        mismatches++;
      end
    end
    shadow_cfg = c;
  endtask

  // One poll as a sensor master would send it: a request, an id, then
  // enough ticks to run the answer out. Frame writes and line noise are
  // mixed in. A share of the polls is broken on purpose, with a stray byte
  // first, an unknown id, or a byte during the answer delay.
  task automatic run_poll();
    logic [1:0]  target;
    logic [7:0]  id;
    int          len;
    int          ticks;
    int unsigned r;
    target = 2'($urandom_range(0, 2));
    case (target)
      SEL_GPS:   id = shadow_cfg.gps_sensor_code;
      SEL_POWER: id = shadow_cfg.power_sensor_code;
      default:   id = shadow_cfg.vario_sensor_code;
    endcase
    len = frame_length(target);
    r = $urandom_range(0, 99);
    if (r < 8) offer(beat_of(OP_RX, 8'($urandom_range(0, 255)), SEL_GPS, 6'd0, 8'h00));
    offer(beat_of(OP_RX, shadow_cfg.request_code, SEL_GPS, 6'd0, 8'h00));
    if (r >= 8 && r < 18) id = 8'($urandom_range(0, 255));
    offer(beat_of(OP_RX, id, SEL_GPS, 6'd0, 8'h00));
    if (r >= 18 && r < 28)
      offer(beat_of(OP_RX, 8'($urandom_range(0, 255)), SEL_GPS, 6'd0, 8'h00));
    ticks = int'(shadow_cfg.answer_delay_ms) + 1 + (GAP_TICKS + 1) * (len + 1)
            + $urandom_range(0, 3);
    repeat (ticks) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        offer(beat_of(OP_WRITE, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                      6'($urandom_range(0, 63)), 8'($urandom_range(0, 255))));
      else if (r < 12)
        offer(beat_of(OP_RX, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                      6'($urandom_range(0, 63)), 8'($urandom_range(0, 255))));
      else if (r < 14)
        offer(noise_beat());
      else
        offer(beat_of(OP_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                      6'($urandom_range(0, 63)), 8'($urandom_range(0, 255))));
    end
  endtask

  // Scoreboard. Results are checked before the new item's expectation is
  // queued, so that a beat that arrives early is flagged and not matched
  // against the item taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      busy = (psel === 1'b1) && (penable === 1'b1) && (pready === 1'b1);
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        busy = 1'b1;
        if (expected_tx.size() == 0) begin
          $error("result beat with no item waiting for it");
          mismatches++;
        end else begin
          want = expected_tx.pop_front();
          compare_field("tx_valid", 8'(want.tx_valid), 8'(result.tx_valid));
          compare_field("tx_byte", want.tx_byte, result.tx_byte);
          compare_field("tx_last", 8'(want.tx_last), 8'(result.tx_last));
          compare_field("phase", 8'(want.phase), 8'(result.phase));
        end
      end
      if (item_valid === 1'b1 && item_stall === 1'b0) begin
        busy = 1'b1;
        predicted = advance_responder(item);
        if (pin_check) begin
          predicted = '0;
          predicted.phase = pin_phase;
        end
        expected_tx.push_back(predicted);
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: a run of cycles in which no beat moves on any port ends the run.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Result sink. It stalls for random stretches and counts its own long
  // hold-off when the stimulus asks for one.
  initial begin : result_sink
    int unsigned shut;
    int unsigned open;
    result_stall = 1'b0;
    calm_sink = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) calm_sink = !calm_sink;
      shut = hold_off_pending ? LONG_HOLD : pick_gap(calm_sink);
      hold_off_pending = 1'b0;
      open = $urandom_range(1, 6);
      if (shut != 0) begin
        result_stall <= 1'b1;
        repeat (shut) @(negedge clk);
      end
      result_stall <= 1'b0;
      repeat (open) @(negedge clk);
    end
  end

  initial begin : stimulus
    row_t plan[$];
    cfg_t setting;
    int   stage;
    int   budget;
    int   fsel_i;
    int   idx_i;
    int   k;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    pin_check = 1'b0;
    pin_phase = PH_IDLE;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm_sender = 1'b0;
    hold_off_pending = 1'b0;
    mismatches = 0;
    issued = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The store is not cleared by reset, so every entry is written before
    // any answer can read it.
    for (fsel_i = 0; fsel_i < 3; fsel_i++)
      for (idx_i = 0; idx_i < FRAME_BYTES; idx_i++)
        offer(beat_of(OP_WRITE, 8'($urandom_range(0, 255)), 2'(fsel_i), 6'(idx_i),
                      8'($urandom_range(0, 255))));

    // Directed setting: the request is all ones, the GPS and power ids are
    // both zero, so an id of zero picks GPS, and the frames are short.
    setting = '{8'hFF, 8'h00, 8'h00, 8'h89, 7'd3, 7'd2, 7'd3, 4'd1};
    load_settings(setting, 1'b0);

    plan = '{
      row(beat_of(OP_TICK,  8'h00, SEL_GPS,   6'd0,  8'h00), 1'b1, PH_IDLE),
      row(beat_of(2'd3,     8'hFF, 2'd3,      6'd63, 8'hFF), 1'b1, PH_IDLE),
      row(beat_of(OP_WRITE, 8'h00, 2'd3,      6'd63, 8'hFF), 1'b1, PH_IDLE),
      row(beat_of(OP_RX,    8'h00, SEL_GPS,   6'd0,  8'h00), 1'b1, PH_IDLE),
      row(beat_of(OP_RX,    8'hFF, SEL_GPS,   6'd0,  8'h00), 1'b1, PH_AWAIT),
      row(beat_of(OP_TICK,  8'h00, SEL_GPS,   6'd0,  8'h00), 1'b1, PH_AWAIT),
      row(beat_of(OP_RX,    8'h55, SEL_GPS,   6'd0,  8'h00), 1'b1, PH_IDLE),
      row(beat_of(OP_RX,    8'hFF, SEL_GPS,   6'd0,  8'h00), 1'b1, PH_AWAIT),
      row(beat_of(OP_RX,    8'h00, SEL_GPS,   6'd0,  8'h00), 1'b1, PH_GPS),
      row(beat_of(OP_RX,    8'h12, SEL_GPS,   6'd0,  8'h00), 1'b1, PH_IDLE),
      row(beat_of(OP_RX,    8'hFF, SEL_GPS,   6'd0,  8'h00), 1'b1, PH_AWAIT),
      row(beat_of(OP_RX,    8'h89, SEL_GPS,   6'd0,  8'h00), 1'b1, PH_VARIO),
      // From here on, the vario answer runs: first byte, dropped line byte,
      // rewrite of a byte not yet sent, second byte, checksum, back to idle.
      row(beat_of(OP_TICK,  8'h00, SEL_GPS,   6'd0,  8'h00)),
      row(beat_of(OP_TICK,  8'h00, SEL_GPS,   6'd0,  8'h00)),
      row(beat_of(OP_RX,    8'hFF, SEL_GPS,   6'd0,  8'h00)),
      row(beat_of(OP_WRITE, 8'h00, SEL_VARIO, 6'd1,  8'h00)),
      row(beat_of(OP_TICK,  8'h00, SEL_GPS,   6'd0,  8'h00)),
      row(beat_of(OP_TICK,  8'h00, SEL_GPS,   6'd0,  8'h00)),
      row(beat_of(OP_TICK,  8'h00, SEL_GPS,   6'd0,  8'h00)),
      row(beat_of(OP_TICK,  8'h00, SEL_GPS,   6'd0,  8'h00)),
      row(beat_of(OP_TICK,  8'h00, SEL_GPS,   6'd0,  8'h00)),
      row(beat_of(OP_TICK,  8'h00, SEL_GPS,   6'd0,  8'h00))
    };
    for (k = 0; k < plan.size(); k++)
      offer(plan[k].beat, plan[k].pinned, plan[k].ph);

    // Random phases, each under its own setting. The second phase holds the
    // extremes: an over-long GPS frame, an empty power frame, a vario frame
    // that is only a checksum, and the longest delay.
    for (stage = 0; stage < 6; stage++) begin
      setting.request_code      = 8'($urandom_range(0, 255));
      setting.gps_sensor_code   = 8'($urandom_range(0, 255));
      setting.power_sensor_code = 8'($urandom_range(0, 255));
      setting.vario_sensor_code = 8'($urandom_range(0, 255));
      setting.gps_frame_length   = 7'($urandom_range(2, 8));
      setting.power_frame_length = 7'($urandom_range(2, 8));
      setting.vario_frame_length = 7'($urandom_range(2, 8));
      setting.answer_delay_ms    = 4'($urandom_range(0, 3));
      case (stage)
        1: setting = '{8'h00, 8'hFF, 8'h00, 8'h7F, 7'd127, 7'd0, 7'd1, 4'd15};
        2: begin
          setting.gps_frame_length = 7'd64;
          setting.power_frame_length = 7'd2;
          setting.vario_frame_length = 7'd2;
          setting.answer_delay_ms = 4'd0;
        end
        3: begin
          setting.gps_frame_length = 7'($urandom_range(0, 12));
          setting.power_frame_length = 7'($urandom_range(0, 12));
          setting.vario_frame_length = 7'($urandom_range(0, 12));
          setting.answer_delay_ms = 4'($urandom_range(0, 15));
        end
        4: begin
          setting.request_code = 8'd128;
          setting.gps_sensor_code = 8'd138;
          setting.power_sensor_code = 8'd142;
          setting.vario_sensor_code = 8'd137;
          setting.answer_delay_ms = 4'd5;
        end
        default: begin
        end
      endcase
      load_settings(setting, stage[0]);
      // Early in the random part, the sink goes quiet for a long time while
      // polls keep coming, which backs the pipeline up into the item port.
      if (stage == 0) hold_off_pending = 1'b1;
      budget = issued + 40;
      while (issued < budget) begin
        calm_sender = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 99) < 80) run_poll();
        else repeat ($urandom_range(1, 4)) offer(noise_beat());
      end
    end

    park_sender();
    while (expected_tx.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_tx.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
